>>> src/irkp_pkg.sv
// Shared types and constants for the IR keypad RGB level setter.
// Holds the remote code table, status codes and the decoded command type.
// No dependencies.
package irkp_pkg;

	// Default top-of-range for an applied level
	localparam int unsigned LEVEL_MAX_DEF = 255;

	// Remote codes for the command keys
	localparam logic [31:0] CODE_ENTER = 32'd4127850240;
	localparam logic [31:0] CODE_RED   = 32'd3125149440;
	localparam logic [31:0] CODE_GREEN = 32'd3108437760;
	localparam logic [31:0] CODE_BLUE  = 32'd3091726080;

	// Remote codes for digits 0 through 9, indexed by digit value
	localparam int unsigned NUM_DIGITS = 10;
	localparam logic [31:0] DIGIT_CODE [NUM_DIGITS] = '{
		32'd3910598400, 32'd4077715200, 32'd3877175040, 32'd2707357440,
		32'd4144561920, 32'd3810328320, 32'd2774204160, 32'd3175284480,
		32'd2907897600, 32'd3041591040
	};

	// Channel selection codes
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// Per-item status reported with each result
	typedef enum logic [2:0] {
		ST_IGNORED      = 3'd0,
		ST_DIGIT_ADDED  = 3'd1,
		ST_UNKNOWN      = 3'd2,
		ST_CHANNEL_SEL  = 3'd3,
		ST_LEVEL_APPLY  = 3'd4,
		ST_OUT_OF_RANGE = 3'd5
	} status_t;

	// Kind of key a code stands for
	typedef enum logic [2:0] {
		KEY_NONE,
		KEY_ENTER,
		KEY_RED,
		KEY_GREEN,
		KEY_BLUE,
		KEY_DIGIT,
		KEY_UNKNOWN
	} key_kind_t;

	// Decoded command passed from the decoder to the state update
	typedef struct packed {
		key_kind_t  kind;
		logic [3:0] digit;
	} key_cmd_t;

endpackage

>>> src/ir_keypad_rgb_level_setter.sv
// Top level of the IR keypad RGB level setter.
// Registers each code, decodes it, updates entry, channel and levels.
// Depends on irkp_pkg and irkp_decode.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid, in_stall  | ir_code
//   output  | out_valid, out_stall| status, red_level, green_level,
//           |                     | blue_level, channel, entry_value
//
// One item per cycle sustained while out_stall is low; an item is taken into the
// input register, then moves on into the result register and shows on the outputs.
// Decode and state update are combinational between the two registers.
// arst_n clears entry, channel selection, levels and both valid flags.
// out_stall holds the result register; the input register keeps accepting
// until it is full, then in_stall rises in the same cycle.
module ir_keypad_rgb_level_setter import irkp_pkg::*; #(
	parameter int unsigned LEVEL_MAX = LEVEL_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] ir_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  red_level,
	output logic [7:0]  green_level,
	output logic [7:0]  blue_level,
	output logic [1:0]  channel,
	output logic [8:0]  entry_value
);

	// Accumulator holds up to LEVEL_MAX + 1, and at least 9 bits for the port
	localparam int unsigned SAT_BITS = $clog2(LEVEL_MAX + 2);
	localparam int unsigned ACC_W    = (SAT_BITS > 9) ? SAT_BITS : 9;
	localparam int unsigned MUL_W    = ACC_W + 4;
	localparam logic [ACC_W-1:0] ENTRY_SAT = ACC_W'(LEVEL_MAX + 1);

	logic             valid_s1;
	logic [31:0]      code_s1;
	logic             advance;
	key_cmd_t         cmd;

	logic [ACC_W-1:0] acc_q,   acc_d;
	logic [1:0]       sel_q,   sel_d;
	logic [7:0]       red_q,   red_d;
	logic [7:0]       green_q, green_d;
	logic [7:0]       blue_q,  blue_d;
	status_t          st_d;
	logic [MUL_W-1:0] prod;

	logic             out_valid_q;
	status_t          status_q;
	logic [7:0]       red_out_q, green_out_q, blue_out_q;
	logic [1:0]       channel_q;
	logic [8:0]       entry_q;

	// Move the held item into the result register when it is free or drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			code_s1 <= ir_code;
		end
	end

	irkp_decode u_decode (
		.code (code_s1),
		.cmd  (cmd)
	);

	// Entry times ten plus the digit
	assign prod = (MUL_W'(acc_q) << 3) + (MUL_W'(acc_q) << 1) + MUL_W'(cmd.digit);

	// Next state and status for the item in the input register
	always_comb begin
		acc_d   = acc_q;
		sel_d   = sel_q;
		red_d   = red_q;
		green_d = green_q;
		blue_d  = blue_q;
		st_d    = ST_IGNORED;
		case (cmd.kind)
			KEY_NONE: begin
				st_d = ST_IGNORED;
			end
			KEY_ENTER: begin
				if (acc_q < ENTRY_SAT) begin
					case (sel_q)
						CH_RED:   red_d   = acc_q[7:0];
						CH_GREEN: green_d = acc_q[7:0];
						default:  blue_d  = acc_q[7:0];
					endcase
					st_d = ST_LEVEL_APPLY;
				end else begin
					st_d = ST_OUT_OF_RANGE;
				end
				acc_d = '0;
			end
			KEY_RED: begin
				sel_d = CH_RED;
				st_d  = ST_CHANNEL_SEL;
			end
			KEY_GREEN: begin
				sel_d = CH_GREEN;
				st_d  = ST_CHANNEL_SEL;
			end
			KEY_BLUE: begin
				sel_d = CH_BLUE;
				st_d  = ST_CHANNEL_SEL;
			end
			KEY_DIGIT: begin
				if (acc_q >= ENTRY_SAT || prod > MUL_W'(ENTRY_SAT)) begin
					acc_d = ENTRY_SAT;
				end else begin
					acc_d = prod[ACC_W-1:0];
				end
				st_d = ST_DIGIT_ADDED;
			end
			default: begin
				st_d = ST_UNKNOWN;
			end
		endcase
	end

	// Commit state as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			sel_q   <= CH_RED;
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
		end else if (advance) begin
			acc_q   <= acc_d;
			sel_q   <= sel_d;
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result payload, loaded with the state after the item
	always_ff @(posedge clk) begin
		if (advance) begin
			status_q    <= st_d;
			red_out_q   <= red_d;
			green_out_q <= green_d;
			blue_out_q  <= blue_d;
			channel_q   <= sel_d;
			entry_q     <= acc_d[8:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign red_level   = red_out_q;
	assign green_level = green_out_q;
	assign blue_level  = blue_out_q;
	assign channel     = channel_q;
	assign entry_value = entry_q;

`ifndef NO_ASSERTIONS
	// Entry never climbs past the saturation value
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= ENTRY_SAT)
		else $error("entry accumulator beyond saturation");

	// Selected channel is always red, green or blue
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q != 2'd3)
		else $error("selected channel out of range");

	// An enter result always shows a cleared entry
	a_enter_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_LEVEL_APPLY || status_q == ST_OUT_OF_RANGE)
		|-> entry_q == 9'd0)
		else $error("entry not cleared after enter");

	// Channel levels move only when an item is committed
	a_levels_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(red_q) && $stable(green_q) && $stable(blue_q))
		else $error("channel level changed without an item");
`endif

endmodule

>>> src/irkp_decode.sv
// Code decoder for the IR keypad RGB level setter.
// Compares one raw remote code against all key codes in parallel.
// Depends on irkp_pkg.
module irkp_decode import irkp_pkg::*; (
	input  logic [31:0] code,
	output key_cmd_t    cmd
);

	logic [NUM_DIGITS-1:0] digit_hit;
	logic [3:0]            digit_val;

	// Match every digit code at once
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			digit_hit[i] = (code == DIGIT_CODE[i]);
		end
	end

	// Encode the matching digit; codes are distinct so at most one hits
	always_comb begin
		digit_val = 4'd0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (digit_hit[i]) begin
				digit_val = 4'(i);
			end
		end
	end

	// Classify the code, zero first
	always_comb begin
		cmd.digit = digit_val;
		if (code == 32'd0) begin
			cmd.kind = KEY_NONE;
		end else if (code == CODE_ENTER) begin
			cmd.kind = KEY_ENTER;
		end else if (code == CODE_RED) begin
			cmd.kind = KEY_RED;
		end else if (code == CODE_GREEN) begin
			cmd.kind = KEY_GREEN;
		end else if (code == CODE_BLUE) begin
			cmd.kind = KEY_BLUE;
		end else if (|digit_hit) begin
			cmd.kind = KEY_DIGIT;
		end else begin
			cmd.kind = KEY_UNKNOWN;
		end
	end

endmodule
